### src/cdlq_pkg.sv
// Package for the circular doubly linked queue: command and status codes,
// and the write-enable group passed from the sequencer to the link store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cdlq_pkg;

	typedef enum logic [3:0] {
		CMD_APPEND   = 4'd0,
		CMD_REMOVE   = 4'd1,
		CMD_MOVE_UP  = 4'd2,
		CMD_MOVE_DN  = 4'd3,
		CMD_ROT_FWD  = 4'd4,
		CMD_ROT_BACK = 4'd5,
		CMD_NEXT     = 4'd6,
		CMD_PREV     = 4'd7,
		CMD_FIND     = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_FEW   = 3'd1,
		ST_FULL      = 3'd2,
		ST_BAD_HNDL  = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic next_we;
		logic prev_we;
		logic id_we;
	} store_wen_t;

endpackage
`default_nettype wire

### src/cdlq_if.sv
// Request and response channel interfaces of the queue.
// Depends on nothing; payload widths are fixed by the command format.
`timescale 1ns / 1ps
`default_nettype none
interface cdlq_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  cmd;
	logic [15:0] item_id;
	logic [3:0]  node_handle;
	modport source (output valid, cmd, item_id, node_handle, input ready);
	modport sink (input valid, cmd, item_id, node_handle, output ready);
endinterface

interface cdlq_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  result_handle;
	logic [15:0] result_id;
	logic [4:0]  entry_count;
	logic [3:0]  current_handle;
	modport source (output valid, status, result_handle, result_id, entry_count,
		current_handle, input ready);
	modport sink (input valid, status, result_handle, result_id, entry_count,
		current_handle, output ready);
endinterface
`default_nettype wire

### src/cdlq_store.sv
// Node pool storage: next link, prev link and id arrays, one shared read
// address with registered read data, one write port per array.
// Depends on cdlq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cdlq_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int IW    = 16
) (
	input  wire logic                 clk,
	input  wire logic [AW-1:0]        rd_addr,
	input  wire cdlq_pkg::store_wen_t wen,
	input  wire logic [AW-1:0]        next_waddr,
	input  wire logic [AW-1:0]        next_wdata,
	input  wire logic [AW-1:0]        prev_waddr,
	input  wire logic [AW-1:0]        prev_wdata,
	input  wire logic [AW-1:0]        id_waddr,
	input  wire logic [IW-1:0]        id_wdata,
	output logic      [AW-1:0]        rd_next,
	output logic      [AW-1:0]        rd_prev,
	output logic      [IW-1:0]        rd_id
);

	logic [AW-1:0] next_mem [DEPTH];
	logic [AW-1:0] prev_mem [DEPTH];
	logic [IW-1:0] id_mem   [DEPTH];

	// write ports
	always_ff @(posedge clk) begin
		if (wen.next_we) next_mem[next_waddr] <= next_wdata;
		if (wen.prev_we) prev_mem[prev_waddr] <= prev_wdata;
		if (wen.id_we)   id_mem[id_waddr]     <= id_wdata;
	end

	// registered read of all three fields
	always_ff @(posedge clk) begin
		rd_next <= next_mem[rd_addr];
		rd_prev <= prev_mem[rd_addr];
		rd_id   <= id_mem[rd_addr];
	end

endmodule
`default_nettype wire

### src/circular_doubly_linked_queue_top.sv
// Circular doubly linked queue over a pool of POOL_DEPTH nodes, one request at a time.
// Errors, unknown codes, two-entry moves and removal of the last entry go straight to the
// response stage; append scans for the lowest free slot, and find walks from head, one node
// per cycle. A response may wait in its register while the next request is taken.
// Reset clears pointers, count and used bits; the link store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module circular_doubly_linked_queue_top #(
	parameter int POOL_DEPTH = 16,
	parameter int ID_BITS    = 16
) (
	input wire logic   clk,
	input wire logic   arst_n,
	cdlq_req_if.sink   req,
	cdlq_rsp_if.source rsp
);

	localparam int PW = $clog2(POOL_DEPTH);
	localparam int CW = $clog2(POOL_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_APP2, S_RM, S_MV_DN, S_MV_N, S_MV_P, S_MV_W2, S_MV_W3,
		S_ROT1, S_ROT2, S_NB1, S_NB2, S_FIND, S_OUT
	} state_t;

	state_t                 state_q;
	cdlq_pkg::cmd_t         cmd_q;
	logic [ID_BITS-1:0]     id_q;
	logic [PW-1:0]          h_q, head_q, tail_q, cur_q, scan_q, walk_q;
	logic [PW-1:0]          n_q, p_q, nn_q, pp_q;
	logic [CW-1:0]          count_q, idx_q;
	logic [POOL_DEPTH-1:0]  used_q;
	cdlq_pkg::status_t      res_st_q;
	logic [3:0]             res_h_q;
	logic [15:0]            res_id_q;

	logic                   rsp_valid_q;
	logic [2:0]             rsp_status_q;
	logic [3:0]             rsp_handle_q;
	logic [15:0]            rsp_id_q;
	logic [4:0]             rsp_count_q;
	logic [3:0]             rsp_cur_q;

	logic [PW-1:0]          rd_addr, rd_next, rd_prev;
	logic [ID_BITS-1:0]     rd_id;
	cdlq_pkg::store_wen_t   wen;
	logic [PW-1:0]          next_waddr, next_wdata, prev_waddr, prev_wdata, id_waddr;

	logic                   accept;
	logic [PW-1:0]          h_idx;
	logic                   h_ok;
	cdlq_pkg::cmd_t         in_cmd;
	logic                   fwd_q;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_cmd    = cdlq_pkg::cmd_t'(req.cmd);
	assign h_idx     = PW'(req.node_handle);
	assign h_ok      = ({28'd0, req.node_handle} < 32'(POOL_DEPTH)) && used_q[h_idx];
	assign fwd_q     = (cmd_q == cdlq_pkg::CMD_ROT_FWD) || (cmd_q == cdlq_pkg::CMD_NEXT);

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.result_handle  = rsp_handle_q;
	assign rsp.result_id      = rsp_id_q;
	assign rsp.entry_count    = rsp_count_q;
	assign rsp.current_handle = rsp_cur_q;

	cdlq_store #(.DEPTH(POOL_DEPTH), .AW(PW), .IW(ID_BITS)) u_store (
		.clk        (clk),
		.rd_addr    (rd_addr),
		.wen        (wen),
		.next_waddr (next_waddr),
		.next_wdata (next_wdata),
		.prev_waddr (prev_waddr),
		.prev_wdata (prev_wdata),
		.id_waddr   (id_waddr),
		.id_wdata   (id_q),
		.rd_next    (rd_next),
		.rd_prev    (rd_prev),
		.rd_id      (rd_id)
	);

	// drive store reads and writes from the sequencer state
	always_comb begin
		rd_addr    = h_idx;
		wen        = '0;
		next_waddr = n_q;
		next_wdata = n_q;
		prev_waddr = n_q;
		prev_wdata = n_q;
		id_waddr   = scan_q;
		case (state_q)
			S_IDLE: begin
				if (in_cmd == cdlq_pkg::CMD_ROT_FWD || in_cmd == cdlq_pkg::CMD_ROT_BACK ||
					in_cmd == cdlq_pkg::CMD_FIND)
					rd_addr = head_q;
			end
			S_SCAN: begin
				if (!used_q[scan_q]) begin
					wen = '{next_we: 1'b1, prev_we: 1'b1, id_we: 1'b1};
					next_waddr = scan_q;
					prev_waddr = scan_q;
					next_wdata = (count_q == '0) ? scan_q : head_q;
					prev_wdata = (count_q == '0) ? scan_q : tail_q;
				end
			end
			S_APP2: begin
				wen.next_we = 1'b1;
				wen.prev_we = 1'b1;
				next_waddr  = tail_q;
				next_wdata  = n_q;
				prev_waddr  = head_q;
				prev_wdata  = n_q;
			end
			S_RM: begin
				wen.next_we = 1'b1;
				wen.prev_we = 1'b1;
				next_waddr  = rd_prev;
				next_wdata  = rd_next;
				prev_waddr  = rd_next;
				prev_wdata  = rd_prev;
			end
			S_MV_DN: rd_addr = rd_next;
			S_MV_N:  rd_addr = rd_prev;
			S_MV_P: begin
				wen.next_we = 1'b1;
				wen.prev_we = 1'b1;
				next_waddr  = rd_prev;
				next_wdata  = n_q;
				prev_waddr  = nn_q;
				prev_wdata  = p_q;
			end
			S_MV_W2: begin
				wen.next_we = 1'b1;
				wen.prev_we = 1'b1;
				next_waddr  = n_q;
				next_wdata  = p_q;
				prev_waddr  = n_q;
				prev_wdata  = pp_q;
			end
			S_MV_W3: begin
				wen.next_we = 1'b1;
				wen.prev_we = 1'b1;
				next_waddr  = p_q;
				next_wdata  = nn_q;
				prev_waddr  = p_q;
				prev_wdata  = n_q;
			end
			S_ROT1:  rd_addr = tail_q;
			S_NB1:   rd_addr = fwd_q ? rd_next : rd_prev;
			S_FIND:  rd_addr = rd_next;
			default: rd_addr = h_idx;
		endcase
	end

	// sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cur_q       <= '0;
			count_q     <= '0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= in_cmd;
						id_q     <= ID_BITS'(req.item_id);
						h_q      <= h_idx;
						res_st_q <= cdlq_pkg::ST_OK;
						res_h_q  <= '0;
						res_id_q <= '0;
						state_q  <= S_OUT;
						case (in_cmd)
							cdlq_pkg::CMD_APPEND: begin
								if (count_q == CW'(POOL_DEPTH)) res_st_q <= cdlq_pkg::ST_FULL;
								else begin
									scan_q  <= '0;
									state_q <= S_SCAN;
								end
							end
							cdlq_pkg::CMD_REMOVE: begin
								if (!h_ok || count_q == '0) res_st_q <= cdlq_pkg::ST_BAD_HNDL;
								else if (count_q == CW'(1)) begin
									head_q        <= '0;
									tail_q        <= '0;
									cur_q         <= '0;
									used_q[h_idx] <= 1'b0;
									count_q       <= count_q - CW'(1);
								end else state_q <= S_RM;
							end
							cdlq_pkg::CMD_MOVE_UP, cdlq_pkg::CMD_MOVE_DN: begin
								if (count_q < CW'(2)) res_st_q <= cdlq_pkg::ST_TOO_FEW;
								else if (!h_ok) res_st_q <= cdlq_pkg::ST_BAD_HNDL;
								else if (count_q == CW'(2)) begin
									head_q <= tail_q;
									tail_q <= head_q;
								end else if (in_cmd == cdlq_pkg::CMD_MOVE_UP) begin
									n_q     <= h_idx;
									state_q <= S_MV_N;
								end else state_q <= S_MV_DN;
							end
							cdlq_pkg::CMD_ROT_FWD, cdlq_pkg::CMD_ROT_BACK: begin
								if (count_q < CW'(2)) res_st_q <= cdlq_pkg::ST_TOO_FEW;
								else state_q <= S_ROT1;
							end
							cdlq_pkg::CMD_NEXT, cdlq_pkg::CMD_PREV: begin
								if (!h_ok) res_st_q <= cdlq_pkg::ST_BAD_HNDL;
								else state_q <= S_NB1;
							end
							cdlq_pkg::CMD_FIND: begin
								if (count_q == '0) res_st_q <= cdlq_pkg::ST_NOT_FOUND;
								else begin
									walk_q  <= head_q;
									idx_q   <= '0;
									state_q <= S_FIND;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				// look for the lowest free slot, one per cycle
				S_SCAN: begin
					if (!used_q[scan_q]) begin
						used_q[scan_q] <= 1'b1;
						res_h_q        <= 4'(scan_q);
						res_id_q       <= 16'(id_q);
						if (count_q == '0) begin
							head_q  <= scan_q;
							tail_q  <= scan_q;
							cur_q   <= scan_q;
							count_q <= count_q + CW'(1);
							state_q <= S_OUT;
						end else begin
							n_q     <= scan_q;
							state_q <= S_APP2;
						end
					end else scan_q <= scan_q + PW'(1);
				end
				S_APP2: begin
					tail_q  <= n_q;
					count_q <= count_q + CW'(1);
					state_q <= S_OUT;
				end
				// unlink the node whose links just came back
				S_RM: begin
					if (head_q == h_q) head_q <= rd_next;
					if (tail_q == h_q) tail_q <= rd_prev;
					if (cur_q == h_q)  cur_q  <= rd_next;
					used_q[h_q] <= 1'b0;
					count_q     <= count_q - CW'(1);
					state_q     <= S_OUT;
				end
				S_MV_DN: begin
					n_q     <= rd_next;
					state_q <= S_MV_N;
				end
				S_MV_N: begin
					p_q     <= rd_prev;
					nn_q    <= rd_next;
					state_q <= S_MV_P;
				end
				S_MV_P: begin
					pp_q    <= rd_prev;
					state_q <= S_MV_W2;
				end
				S_MV_W2: state_q <= S_MV_W3;
				S_MV_W3: begin
					if (head_q == p_q) head_q <= n_q;
					else if (head_q == n_q) head_q <= p_q;
					if (tail_q == n_q) tail_q <= p_q;
					else if (tail_q == p_q) tail_q <= n_q;
					state_q <= S_OUT;
				end
				S_ROT1: begin
					n_q     <= fwd_q ? rd_next : rd_prev;
					state_q <= S_ROT2;
				end
				S_ROT2: begin
					head_q  <= n_q;
					tail_q  <= fwd_q ? rd_next : rd_prev;
					state_q <= S_OUT;
				end
				S_NB1: begin
					n_q     <= fwd_q ? rd_next : rd_prev;
					state_q <= S_NB2;
				end
				S_NB2: begin
					res_h_q  <= 4'(n_q);
					res_id_q <= 16'(rd_id);
					state_q  <= S_OUT;
				end
				// walk from head, one node per cycle
				S_FIND: begin
					if (rd_id == id_q) begin
						res_h_q  <= 4'(walk_q);
						res_id_q <= 16'(rd_id);
						state_q  <= S_OUT;
					end else if (idx_q + CW'(1) == count_q) begin
						res_st_q <= cdlq_pkg::ST_NOT_FOUND;
						state_q  <= S_OUT;
					end else begin
						walk_q <= rd_next;
						idx_q  <= idx_q + CW'(1);
					end
				end
				// hand the result to the response register once it is free
				S_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_st_q;
						rsp_handle_q <= res_h_q;
						rsp_id_q     <= res_id_q;
						rsp_count_q  <= 5'(count_q);
						rsp_cur_q    <= 4'(cur_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
